// ===== design/vna_pkg.sv =====
package vna_pkg;

   localparam int unsigned MaxVerticesDefault = 1024;
   localparam int unsigned SumWidth = 64;
   localparam int unsigned EntryWidth = 3 * SumWidth;
   localparam int unsigned ReqDataWidth = 224;
   localparam int unsigned RspDataWidth = 64;
   localparam logic [1:0] DIM_2D = 2'd2;
   localparam logic [1:0] DIM_3D = 2'd3;
   localparam logic FUNC_ACCUM = 1'b0;
   localparam logic FUNC_READ = 1'b1;
   localparam logic [63:0] SMALL_SQ = 64'd1152921;

   typedef logic signed [SumWidth-1:0] sum_type;

   function automatic sum_type sat_add(input sum_type a, input sum_type b);
      logic signed [SumWidth:0] s;
      begin
         s = {a[SumWidth-1], a} + {b[SumWidth-1], b};
         if (s[SumWidth] != s[SumWidth-1]) begin
            sat_add = s[SumWidth] ? {1'b1, {(SumWidth-1){1'b0}}}
                                  : {1'b0, {(SumWidth-1){1'b1}}};
         end else begin
            sat_add = s[SumWidth-1:0];
         end
      end
   endfunction

   function automatic logic [SumWidth-1:0] mag(input sum_type c);
      mag = c[SumWidth-1] ? (~c + 64'd1) : c;
   endfunction

endpackage

// ===== design/vna_ram.sv =====
module vna_ram #(
   parameter int unsigned DEPTH = vna_pkg::MaxVerticesDefault,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [AW-1:0]                      wr_addr,
   input  logic [vna_pkg::EntryWidth-1:0]     wr_data,
   input  logic                               rd_en,
   input  logic [AW-1:0]                      rd_addr,
   output logic [vna_pkg::EntryWidth-1:0]     rd_data_ff
);

   logic [vna_pkg::EntryWidth-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

// ===== design/vna_mul.sv =====
module vna_mul (
   input  logic               clock,
   input  logic signed [32:0] op_a,
   input  logic signed [32:0] op_b,
   output logic signed [63:0] prod_ff
);

   logic signed [65:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in[63:0];
   end

endmodule

// ===== design/vertex_normal_accumulator.sv =====
// Vertex normal accumulator.
// req channel: one transfer per face corner (tuser = 0, accumulate) or per
// normal read (tuser = 1). rsp channel: one transfer per read, carrying the
// vertex index, the unit normal in Q1.14 and the was_zero flag in tuser.
// csr_wr_en/csr_wr_data write dimension_mode (2 = planar, else 3D); write it
// only while the block is idle.
// An accumulate holds req_tready low while it runs: a memory read, one
// multiply and one saturating add per component on the shared multiplier,
// then a write back.
// A read holds it low through up to 33 one-bit normalizing shifts, 3
// multiplier passes for the squares (5 when the planar small-sum check runs),
// the square root and a division per component; a zero sum or a small
// planar sum ends early, with no square root or division.
// req_tready is high only while the sequencer waits for an item.
// After reset the block clears all MAX_VERTICES entries, one per cycle, and
// holds req_tready low until the clearing pass is done; dimension_mode resets
// to 3D. A result waits in the rsp register while the receiver stalls; the
// next item is accepted meanwhile, and a later read waits only if its own
// result finds the register still full.
module vertex_normal_accumulator #(
   parameter int unsigned MAX_VERTICES = vna_pkg::MaxVerticesDefault,
   localparam int unsigned AW = $clog2(MAX_VERTICES)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // vertex_index, face_nx, face_ny, face_nz, corner_area, prev_x, prev_y,
   // next_x, next_y, zero pad
   input  logic [vna_pkg::ReqDataWidth-1:0]   req_tdata,
   // func
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // vertex_out, normal_x, normal_y, normal_z, zero pad
   output logic [vna_pkg::RspDataWidth-1:0]   rsp_tdata,
   // was_zero
   output logic                               rsp_tuser,
   input  logic                               csr_wr_en,
   input  logic [1:0]                         csr_wr_data
);

   typedef enum logic [15:0] {
      ST_CLEAR = 16'h0001,
      ST_IDLE  = 16'h0002,
      ST_READ  = 16'h0004,
      ST_LOAD  = 16'h0008,
      ST_MUL   = 16'h0010,
      ST_ADD   = 16'h0020,
      ST_WB    = 16'h0040,
      ST_MAG   = 16'h0080,
      ST_CHECK = 16'h0100,
      ST_SQM   = 16'h0200,
      ST_SQA   = 16'h0400,
      ST_SHIFT = 16'h0800,
      ST_SQRT  = 16'h1000,
      ST_DSET  = 16'h2000,
      ST_DIV   = 16'h4000,
      ST_DONE  = 16'h8000
   } state_type;

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [1:0] mode_ff, mode_in;
   logic two_d_ff, two_d_in;
   logic func_ff, func_in;
   logic [9:0] vi_ff, vi_in;
   logic signed [15:0] fn_ff [3];
   logic signed [15:0] fn_in [3];
   logic [31:0] area_ff, area_in;
   logic signed [32:0] dy_ff, dy_in, ndx_ff, ndx_in;
   vna_pkg::sum_type c_ff [3];
   vna_pkg::sum_type c_in [3];
   logic [63:0] a_ff [3];
   logic [63:0] a_in [3];
   logic [1:0] k_ff, k_in;
   logic [63:0] s_ff, s_in;
   logic final_ff, final_in;
   logic [63:0] v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [4:0] it_ff, it_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [15:0] res_ff [3];
   logic [15:0] res_in [3];
   logic zero_ff, zero_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [vna_pkg::RspDataWidth-1:0] rsp_data_ff, rsp_data_in;
   logic rsp_zero_ff, rsp_zero_in;

   logic ram_we, ram_re;
   logic [AW-1:0] ram_waddr, addr;
   logic [vna_pkg::EntryWidth-1:0] ram_wdata, ram_rdata;
   logic signed [32:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic [31:0] idx32;
   logic req_ok;
   logic [63:0] m_max, m01, sq_t, s_next;
   logic [45:0] div_num;
   logic [3:0] div_j;
   logic [32:0] rem_sh;
   logic [15:0] q_next;
   logic [1:0] last_k;

   vna_ram #(.DEPTH(MAX_VERTICES)) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (ram_waddr),
      .wr_data    (ram_wdata),
      .rd_en      (ram_re),
      .rd_addr    (addr),
      .rd_data_ff (ram_rdata)
   );

   vna_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_p)
   );

   assign idx32 = {22'd0, vi_ff};
   assign addr = idx32[AW-1:0];
   assign req_ok = {22'd0, req_tdata[9:0]} < 32'(MAX_VERTICES);
   assign m01 = (a_ff[0] > a_ff[1]) ? a_ff[0] : a_ff[1];
   assign m_max = (m01 > a_ff[2]) ? m01 : a_ff[2];
   assign sq_t = r_ff + bit_ff;
   assign s_next = s_ff + 64'(mul_p);
   assign div_num = {1'b0, a_ff[k_ff][30:0], 14'd0} + {15'd0, len_ff[31:1]};
   assign div_j = 4'd15 - it_ff[3:0];
   assign rem_sh = {rem_ff[31:0], div_num[div_j]};
   assign q_next = {q_ff[14:0], rem_sh >= {1'b0, len_ff}};
   assign last_k = two_d_ff ? 2'd1 : 2'd2;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_zero_ff;

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      mode_in = csr_wr_en ? csr_wr_data : mode_ff;
      two_d_in = two_d_ff;
      func_in = func_ff;
      vi_in = vi_ff;
      fn_in = fn_ff;
      area_in = area_ff;
      dy_in = dy_ff;
      ndx_in = ndx_ff;
      c_in = c_ff;
      a_in = a_ff;
      k_in = k_ff;
      s_in = s_ff;
      final_in = final_ff;
      v_in = v_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      it_in = it_ff;
      len_in = len_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      res_in = res_ff;
      zero_in = zero_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff;
      rsp_zero_in = rsp_zero_ff;
      ram_we = 1'b0;
      ram_re = 1'b0;
      ram_waddr = addr;
      ram_wdata = '0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_waddr = clr_ff;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_VERTICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               two_d_in = (mode_ff == vna_pkg::DIM_2D);
               func_in = req_tuser;
               vi_in = req_tdata[9:0];
               fn_in[0] = req_tdata[25:10];
               fn_in[1] = req_tdata[41:26];
               fn_in[2] = req_tdata[57:42];
               area_in = req_tdata[89:58];
               ndx_in = {req_tdata[121], req_tdata[121:90]}
                      - {req_tdata[185], req_tdata[185:154]};
               dy_in = {req_tdata[217], req_tdata[217:186]}
                     - {req_tdata[153], req_tdata[153:122]};
               zero_in = 1'b0;
               res_in = '{default: 16'd0};
               if (req_ok) begin
                  state_in = ST_READ;
               end else if (req_tuser == vna_pkg::FUNC_READ) begin
                  zero_in = 1'b1;
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            ram_re = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            c_in[0] = ram_rdata[63:0];
            c_in[1] = ram_rdata[127:64];
            c_in[2] = ram_rdata[191:128];
            k_in = 2'd0;
            if (func_ff == vna_pkg::FUNC_READ) begin
               if (two_d_ff) begin
                  c_in[2] = '0;
               end
               ram_we = 1'b1;
               state_in = ST_MAG;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (two_d_ff) begin
               mul_a = 33'(fn_ff[2]);
               mul_b = (k_ff == 2'd0) ? dy_ff : ndx_ff;
            end else begin
               mul_a = 33'(fn_ff[k_ff]);
               mul_b = {1'b0, area_ff};
            end
            state_in = ST_ADD;
         end
         ST_ADD: begin
            c_in[k_ff] = vna_pkg::sat_add(c_ff[k_ff], mul_p);
            if (k_ff == last_k) begin
               state_in = ST_WB;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_WB: begin
            ram_we = 1'b1;
            ram_wdata = {c_ff[2], c_ff[1], c_ff[0]};
            state_in = ST_IDLE;
         end
         ST_MAG: begin
            for (int i = 0; i < 3; i++) begin
               a_in[i] = vna_pkg::mag(c_ff[i]);
            end
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            s_in = '0;
            k_in = 2'd0;
            if (m_max == 64'd0) begin
               zero_in = 1'b1;
               state_in = ST_DONE;
            end else if (two_d_ff && m_max < 64'h8000_0000) begin
               final_in = 1'b0;
               state_in = ST_SQM;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SQM: begin
            mul_a = {2'b0, a_ff[k_ff][30:0]};
            mul_b = {2'b0, a_ff[k_ff][30:0]};
            state_in = ST_SQA;
         end
         ST_SQA: begin
            s_in = s_next;
            if (k_ff != (final_ff ? 2'd2 : 2'd1)) begin
               k_in = k_ff + 2'd1;
               state_in = ST_SQM;
            end else if (final_ff) begin
               v_in = s_next;
               r_in = '0;
               bit_in = 64'h4000_0000_0000_0000;
               it_in = '0;
               state_in = ST_SQRT;
            end else if (s_next <= vna_pkg::SMALL_SQ) begin
               zero_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (m_max >= 64'h8000_0000) begin
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] >> 1;
            end else if (m_max < 64'h4000_0000) begin
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] << 1;
            end else begin
               final_in = 1'b1;
               s_in = '0;
               k_in = 2'd0;
               state_in = ST_SQM;
            end
         end
         ST_SQRT: begin
            if (v_ff >= sq_t) begin
               v_in = v_ff - sq_t;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd31) begin
               len_in = r_in[31:0];
               k_in = 2'd0;
               state_in = ST_DSET;
            end
         end
         ST_DSET: begin
            rem_in = {3'd0, div_num[45:16]};
            q_in = '0;
            it_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = (rem_sh >= {1'b0, len_ff}) ? rem_sh - {1'b0, len_ff} : rem_sh;
            q_in = q_next;
            it_in = it_ff + 5'd1;
            if (it_ff == 5'd15) begin
               res_in[k_ff] = c_ff[k_ff][63] ? (16'd0 - q_next) : q_next;
               if (k_ff == 2'd2) begin
                  state_in = ST_DONE;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = ST_DSET;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'd0, res_ff[2], res_ff[1], res_ff[0], vi_ff};
               if (two_d_ff || zero_ff) begin
                  rsp_data_in[57:42] = '0;
               end
               rsp_zero_in = zero_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
         mode_ff <= vna_pkg::DIM_3D;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         mode_ff <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      two_d_ff <= two_d_in;
      func_ff <= func_in;
      vi_ff <= vi_in;
      fn_ff <= fn_in;
      area_ff <= area_in;
      dy_ff <= dy_in;
      ndx_ff <= ndx_in;
      c_ff <= c_in;
      a_ff <= a_in;
      k_ff <= k_in;
      s_ff <= s_in;
      final_ff <= final_in;
      v_ff <= v_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      it_ff <= it_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      res_ff <= res_in;
      zero_ff <= zero_in;
      rsp_data_ff <= rsp_data_in;
      rsp_zero_ff <= rsp_zero_in;
   end

endmodule

// ===== design/vna_checker.sv =====
module vna_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [vna_pkg::RspDataWidth-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready) else $error("ready during clearing pass");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready right after transfer");

   a_zero_normal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[57:10] == 48'd0)
      else $error("nonzero normal flagged zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

endmodule

bind vertex_normal_accumulator vna_checker u_vna_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   typedef struct {
      logic               func;
      logic [9:0]         vertex;
      logic signed [15:0] nx, ny, nz;
      logic [31:0]        area;
      logic signed [31:0] px, py, qx, qy;
   } corner_type;

   typedef struct {
      logic [9:0]         vertex;
      logic signed [15:0] nx, ny, nz;
      logic               was_zero;
   } normal_type;

   logic clock = 0, reset = 1;
   logic req_tvalid = 0, req_tuser = 0, rsp_tready = 0, csr_wr_en = 0;
   logic [vna_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic [1:0] csr_wr_data = vna_pkg::DIM_3D;
   wire req_tready, rsp_tvalid, rsp_tuser;
   wire [vna_pkg::RspDataWidth-1:0] rsp_tdata;

   logic [1:0] mode = vna_pkg::DIM_3D;
   vna_pkg::sum_type acc_x [1024], acc_y [1024], acc_z [1024];
   normal_type pending_normals [$];
   int errors = 0, cycles = 0;
   bit idle_on = 1;

   vertex_normal_accumulator dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .csr_wr_en, .csr_wr_data
   );

   initial forever #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("vertex_normal_accumulator test failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_tready <= reset ? 1'b0 : (!idle_on || $urandom_range(99) >= 10);

   function automatic vna_pkg::sum_type sadd(vna_pkg::sum_type a, vna_pkg::sum_type b);
      logic signed [64:0] s;
      s = a + b;
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
   endfunction

   function automatic logic [63:0] root64(logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r;
   endfunction

   function automatic normal_type unit_normal(logic [9:0] vi);
      normal_type o;
      vna_pkg::sum_type c [3];
      logic [63:0] a [3], m, s, len, q;
      bit planar, zero;
      planar = (mode == vna_pkg::DIM_2D);
      c[0] = acc_x[vi];
      c[1] = acc_y[vi];
      c[2] = planar ? 0 : acc_z[vi];
      acc_x[vi] = 0; acc_y[vi] = 0; acc_z[vi] = 0;
      m = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? -c[i] : c[i];
         if (a[i] > m) m = a[i];
      end
      if (m == 0) zero = 1;
      else if (planar && m < (64'd1 << 31))
         zero = (a[0]*a[0] + a[1]*a[1]) <= vna_pkg::SMALL_SQ;
      else zero = 0;
      o.vertex = vi; o.nx = 0; o.ny = 0; o.nz = 0; o.was_zero = zero;
      if (!zero) begin
         while (m >= (64'd1 << 31)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) a[i] >>= 1;
         end
         while (m < (64'd1 << 30)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
         end
         s = 0;
         for (int i = 0; i < 3; i++) s += a[i] * a[i];
         len = root64(s);
         q = (a[0] * 16384 + (len >> 1)) / len; o.nx = 16'(c[0] < 0 ? -q : q);
         q = (a[1] * 16384 + (len >> 1)) / len; o.ny = 16'(c[1] < 0 ? -q : q);
         q = (a[2] * 16384 + (len >> 1)) / len; o.nz = 16'(c[2] < 0 ? -q : q);
         if (planar) o.nz = 0;
      end
      return o;
   endfunction

   function automatic void apply_corner(corner_type it);
      logic signed [32:0] dx, dy;
      if (it.func == vna_pkg::FUNC_READ) begin
         pending_normals.push_back(unit_normal(it.vertex));
      end else if (mode == vna_pkg::DIM_2D) begin
         dx = it.qx - it.px;
         dy = it.qy - it.py;
         acc_x[it.vertex] = sadd(acc_x[it.vertex], it.nz * dy);
         acc_y[it.vertex] = sadd(acc_y[it.vertex], -(it.nz * dx));
      end else begin
         acc_x[it.vertex] = sadd(acc_x[it.vertex], it.nx * $signed({1'b0, it.area}));
         acc_y[it.vertex] = sadd(acc_y[it.vertex], it.ny * $signed({1'b0, it.area}));
         acc_z[it.vertex] = sadd(acc_z[it.vertex], it.nz * $signed({1'b0, it.area}));
      end
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      normal_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_normals.size() == 0) report("unexpected transfer", rsp_tdata, 0);
         else begin
            w = pending_normals.pop_front();
            if (rsp_tdata[9:0] != w.vertex) report("vertex_out", rsp_tdata[9:0], w.vertex);
            if (rsp_tdata[25:10] != w.nx) report("normal_x", rsp_tdata[25:10], w.nx);
            if (rsp_tdata[41:26] != w.ny) report("normal_y", rsp_tdata[41:26], w.ny);
            if (rsp_tdata[57:42] != w.nz) report("normal_z", rsp_tdata[57:42], w.nz);
            if (rsp_tdata[63:58] != 0) report("pad", rsp_tdata[63:58], 0);
            if (rsp_tuser != w.was_zero) report("was_zero", rsp_tuser, w.was_zero);
         end
      end
   end

   task automatic send(corner_type it);
      if (idle_on && $urandom_range(99) < 10) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= it.func;
      req_tdata <= {6'd0, it.qy, it.qx, it.py, it.px, it.area, it.nz, it.ny, it.nx, it.vertex};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_corner(it);
   endtask

   function automatic corner_type corner(logic f, logic [9:0] v, int nx, int ny, int nz,
                                         logic [31:0] ar, int px, int py, int qx, int qy);
      corner_type c;
      c.func = f; c.vertex = v; c.nx = 16'(nx); c.ny = 16'(ny); c.nz = 16'(nz);
      c.area = ar;
      c.px = px; c.py = py; c.qx = qx; c.qy = qy;
      return c;
   endfunction

   task automatic write_mode(logic [1:0] m);
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 0;
      mode = m;
   endtask

   function automatic int rnd_norm();
      return int'($urandom_range(32768)) - 16384;
   endfunction

   function automatic corner_type rnd_corner(int read_pct);
      corner_type c;
      c = corner($urandom_range(99) < read_pct, 10'd0, rnd_norm(), rnd_norm(), rnd_norm(),
                 $urandom, $urandom, $urandom, $urandom, $urandom);
      c.vertex = 10'(($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(15));
      if ($urandom_range(3) == 0) c.area = $urandom_range(65536);
      if ($urandom_range(3) == 0) begin
         c.qx = c.px + int'($urandom_range(2000)) - 1000;
         c.qy = c.py + int'($urandom_range(2000)) - 1000;
      end
      return c;
   endfunction

   task automatic test_directed_3d();
      send(corner(vna_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 1023, -16384, 16384, -16384, 32'hFFFFFFFF,
                  0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 1023, -16384, 16384, -16384, 32'hFFFFFFFF,
                  0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 5, 1, 0, 0, 1, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 5, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 6, 16384, 16384, 16384, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 6, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 7, 3, -4, 12, 65536, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 7, -3, 4, 0, 65536, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 7, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 8, 100, 0, 0, 1, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 8, 0, 0, 0, 1, 0, 0, 0, 0));
   endtask

   task automatic test_directed_2d();
      write_mode(vna_pkg::DIM_2D);
      send(corner(vna_pkg::FUNC_ACCUM, 2, 0, 0, 1, 0, 0, 0, 0, 1073));
      send(corner(vna_pkg::FUNC_READ, 2, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 3, 0, 0, 1, 0, 0, 0, 0, 1074));
      send(corner(vna_pkg::FUNC_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_ACCUM, 4, 7, 7, -16384, 5, 32'h7FFFFFFF, 32'h80000000,
                  32'h80000000, 32'h7FFFFFFF));
      send(corner(vna_pkg::FUNC_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 8, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_mode_switch();
      write_mode(2'd0);
      send(corner(vna_pkg::FUNC_ACCUM, 9, 500, -500, 16384, 32'h10000, 0, 0, 0, 0));
      write_mode(vna_pkg::DIM_2D);
      send(corner(vna_pkg::FUNC_ACCUM, 9, 0, 0, 16384, 0, 0, 0, 65536, 65536));
      send(corner(vna_pkg::FUNC_READ, 9, 0, 0, 0, 0, 0, 0, 0, 0));
      write_mode(2'd1);
      send(corner(vna_pkg::FUNC_ACCUM, 10, 0, 0, 16384, 32'h10000, 0, 0, 0, 0));
      send(corner(vna_pkg::FUNC_READ, 10, 0, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_random();
      logic [1:0] modes [4] = '{vna_pkg::DIM_3D, vna_pkg::DIM_2D, 2'd0, vna_pkg::DIM_2D};
      foreach (modes[k]) begin
         write_mode(modes[k]);
         idle_on = (k != 1);
         for (int n = 0; n < 300; n++) send(rnd_corner(25));
      end
      idle_on = 1;
      req_tvalid <= 0;
   endtask

   initial begin
      for (int i = 0; i < 1024; i++) begin
         acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 0;
      test_directed_3d();
      test_directed_2d();
      test_mode_switch();
      test_random();
      @(posedge clock);
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("vertex_normal_accumulator test passed");
      else $display("vertex_normal_accumulator test failed");
      $finish;
   end

endmodule
